// File: rtl/core/utf8_validate_and_escape_macros.svh
// Assertion macros shared by the UTF-8 validator and escaper RTL.
// Included by the front end, the only module that carries concurrent checks; depends on nothing.
`ifndef UTF8_VALIDATE_AND_ESCAPE_MACROS_SVH
`define UTF8_VALIDATE_AND_ESCAPE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTFVE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utfve: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTFVE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utfve: next-cycle check failed");

`endif

// File: rtl/core/utfve_pkg.sv
// Shared types and constants of the UTF-8 validator and escaper.
// Depends on nothing; the top level, front end, token queue and back end import it.
package utfve_pkg;

    localparam int TQ_DEPTH = 2;
    localparam int TQ_AW    = (TQ_DEPTH > 1) ? $clog2(TQ_DEPTH) : 1;

    // One decoded output token: either raw bytes or an escape sequence.
    typedef struct packed {
        logic        esc;
        logic        is_u;
        logic [3:0]  total;
        logic [2:0]  ndig;
        logic [31:0] data;
        logic        last;
    } t_tok;

endpackage

// File: rtl/core/utfve_in_if.sv
// Input channel of the UTF-8 validator and escaper: one text byte per transaction.
// Depends on nothing.
interface utfve_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: rtl/core/utfve_out_if.sv
// Output channel of the UTF-8 validator and escaper: one escaped byte per transaction.
// Depends on nothing.
interface utfve_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/core/utf8_validate_and_escape.sv
// UTF-8 validator and escaper, top level.
// Channels: i_in takes one text byte per transaction with an end-of-text flag;
// o_out gives one byte of the sanitized text per transaction, with last_of_run
// set on the final byte caused by an input byte. An input that only extends an
// incomplete multi-byte sequence produces no output transaction.
// The front end takes one transaction, then resolves one sequence or escaped byte
// at a time and ends with a closing step before it is ready again; a full
// token queue holds it in that state.
// Output runs at one byte per cycle from the back end while the receiver is ready;
// an escape gives 4 to 8 bytes there, so a long run of escapes is limited by the output port.
// A result's first byte passes the input buffer, hold register, queue and output register.
// A two-entry token queue separates the halves; when the receiver stalls the
// output register holds its byte, the queue fills, and the front end stalls with i_in.ready low.
// Reset (synchronous, active low) empties the queue, the output register and
// any held partial sequence; the block is ready in the first cycle after it.
// Depends on utfve_pkg, the channel interfaces and the three submodules.
module utf8_validate_and_escape (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utfve_in_if.sink     i_in,
    utfve_out_if.source  o_out
);
    import utfve_pkg::*;

    logic push_valid;
    t_tok push_tok;
    logic full;
    logic head_valid;
    t_tok head_tok;
    logic pop;

    utfve_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_tok   (push_tok),
        .i_full       (full)
    );

    utfve_tok_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_tok   (push_tok),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head_tok   (head_tok),
        .i_pop        (pop)
    );

    utfve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_tok   (head_tok),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// File: rtl/core/utfve_front.sv
// Front end: accepts input bytes, holds incomplete sequences and decodes them into tokens.
// Depends on utfve_pkg, utfve_in_if and the assertion macro header.
`include "utf8_validate_and_escape_macros.svh"

module utfve_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    utfve_in_if.sink         i_in,
    output logic             o_push_valid,
    output utfve_pkg::t_tok  o_push_tok,
    input  logic             i_full
);
    import utfve_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECODE = 2'b10
    } t_fstate;

    typedef struct packed {
        logic        need_more;
        logic        bad;
        logic [2:0]  len;
        logic [20:0] cp;
    } t_dec;

    function automatic logic is_invisible(input logic [20:0] c);
        return (c == 21'h0000AD) || (c == 21'h00034F) || (c == 21'h00061C) ||
               (c == 21'h00115F) || (c == 21'h001160) || (c == 21'h0017B4) ||
               (c == 21'h0017B5) || (c == 21'h00180E) ||
               (c >= 21'h00200B && c <= 21'h00200F) ||
               (c >= 21'h002028 && c <= 21'h00202E) ||
               (c >= 21'h002060 && c <= 21'h00206F) || (c == 21'h003164) ||
               (c >= 21'h00FE00 && c <= 21'h00FE0F) || (c == 21'h00FEFF) ||
               (c == 21'h00FFA0) || (c >= 21'h00FFF0 && c <= 21'h00FFFB) ||
               (c >= 21'h0E0000 && c <= 21'h0E0FFF);
    endfunction

    function automatic t_dec decode(input logic [3:0][7:0] w, input logic [2:0] avail,
                                    input logic at_end);
        t_dec       d;
        logic [2:0] want;
        logic       stop;
        d    = '0;
        want = 3'd1;
        stop = 1'b0;
        if (w[0] < 8'h80) begin
            d.cp = {13'b0, w[0]};
        end else if (w[0] >= 8'hC2 && w[0] <= 8'hDF) begin
            want = 3'd2;
            d.cp = {16'b0, w[0][4:0]};
        end else if (w[0] >= 8'hE0 && w[0] <= 8'hEF) begin
            want = 3'd3;
            d.cp = {17'b0, w[0][3:0]};
        end else if (w[0] >= 8'hF0 && w[0] <= 8'hF4) begin
            want = 3'd4;
            d.cp = {18'b0, w[0][2:0]};
        end else begin
            d.bad = 1'b1;
            stop  = 1'b1;
        end
        for (int i = 1; i < 4; i++) begin
            if (!stop && 3'(i) < want) begin
                if (3'(i) >= avail) begin
                    d.need_more = !at_end;
                    d.bad       = at_end;
                    stop        = 1'b1;
                end else if (w[i][7:6] != 2'b10) begin
                    d.bad = 1'b1;
                    stop  = 1'b1;
                end else begin
                    d.cp = {d.cp[14:0], w[i][5:0]};
                end
            end
        end
        if (!stop && ((want == 3'd3 && d.cp < 21'h000800) ||
                      (want == 3'd4 && d.cp < 21'h010000) || (d.cp > 21'h10FFFF) ||
                      (d.cp >= 21'h00D800 && d.cp <= 21'h00DFFF))) begin
            d.bad = 1'b1;
        end
        d.len = d.bad ? 3'd1 : want;
        return d;
    endfunction

    t_fstate         r_state, n_state;
    logic [3:0][7:0] r_buf, n_buf;
    logic [2:0]      r_n, n_n;
    logic [2:0]      r_pos, n_pos;
    logic            r_at_end, n_at_end;
    t_tok            r_hold, n_hold;
    logic            r_hold_valid, n_hold_valid;

    logic [3:0][7:0] win;
    logic [2:0]      avail;
    t_dec            dec;
    t_tok            new_tok;
    logic            item_done;
    logic            is_ctl;
    logic            esc_u;
    logic            esc_x;
    logic [2:0]      ndig;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if ((r_pos + 3'(i)) < 3'd4) begin
                win[i] = r_buf[2'(r_pos + 3'(i))];
            end else begin
                win[i] = 8'h00;
            end
        end
    end

    assign avail     = r_n - r_pos;
    assign dec       = decode(win, avail, r_at_end);
    assign item_done = (r_pos == r_n) || dec.need_more;

    always_comb begin
        is_ctl = (dec.cp < 21'h000020) || (dec.cp == 21'h00007F);
        esc_x  = dec.bad || is_ctl;
        esc_u  = !dec.bad && (((dec.cp >= 21'h000080) && (dec.cp <= 21'h00009F)) ||
                              is_invisible(dec.cp));
        if (!esc_u) begin
            ndig = 3'd2;
        end else if (dec.cp > 21'h0FFFFF) begin
            ndig = 3'd6;
        end else if (dec.cp > 21'h00FFFF) begin
            ndig = 3'd5;
        end else begin
            ndig = 3'd4;
        end
        new_tok.esc   = esc_x || esc_u;
        new_tok.is_u  = esc_u;
        new_tok.ndig  = ndig;
        new_tok.total = (esc_x || esc_u) ? ({1'b0, ndig} + 4'd2) : {1'b0, dec.len};
        new_tok.last  = 1'b0;
        if (esc_u) begin
            new_tok.data = {11'b0, dec.cp};
        end else if (esc_x) begin
            new_tok.data = {24'b0, (dec.bad ? win[0] : dec.cp[7:0])};
        end else begin
            new_tok.data = win;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_buf        = r_buf;
        n_n          = r_n;
        n_pos        = r_pos;
        n_at_end     = r_at_end;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        o_push_valid = 1'b0;
        o_push_tok   = r_hold;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_buf[r_n[1:0]] = i_in.in_byte;
                    n_n             = r_n + 3'd1;
                    n_pos           = 3'd0;
                    n_at_end        = i_in.end_of_text;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!r_hold_valid || !i_full) begin
                    o_push_valid = r_hold_valid;
                    if (item_done) begin
                        o_push_tok.last = 1'b1;
                        n_buf[0]        = win[0];
                        n_buf[1]        = win[1];
                        n_buf[2]        = win[2];
                        n_n             = avail;
                        n_pos           = 3'd0;
                        n_hold_valid    = 1'b0;
                        n_state         = ST_IDLE;
                    end else begin
                        o_push_tok.last = 1'b0;
                        n_hold          = new_tok;
                        n_hold_valid    = 1'b1;
                        n_pos           = r_pos + dec.len;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_n          <= 3'd0;
            r_pos        <= 3'd0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_n          <= n_n;
            r_pos        <= n_pos;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf    <= n_buf;
        r_at_end <= n_at_end;
        r_hold   <= n_hold;
    end

    `UTFVE_ASSERT_IMP(a_hold_only_decoding, i_clk, i_rst_n, r_hold_valid, r_state == ST_DECODE)
    `UTFVE_ASSERT_IMP(a_pos_within_item, i_clk, i_rst_n, r_state == ST_DECODE, r_pos <= r_n)
    `UTFVE_ASSERT_NXT(a_accept_starts_decode, i_clk, i_rst_n, i_in.valid && i_in.ready, (r_state == ST_DECODE) && (r_n != 3'd0) && !r_hold_valid)

endmodule

// File: rtl/core/utfve_tok_fifo.sv
// Small token queue between the decoding front end and the byte-emitting back end.
// Depends on utfve_pkg.
module utfve_tok_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  utfve_pkg::t_tok  i_push_tok,
    output logic             o_full,
    output logic             o_head_valid,
    output utfve_pkg::t_tok  o_head_tok,
    input  logic             i_pop
);
    import utfve_pkg::*;

    t_tok               r_mem [TQ_DEPTH];
    logic [TQ_AW-1:0]   r_wr, n_wr;
    logic [TQ_AW-1:0]   r_rd, n_rd;
    logic [TQ_AW:0]     r_cnt, n_cnt;

    assign o_full       = (r_cnt == (TQ_AW + 1)'(TQ_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head_tok   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push_valid) begin
            n_wr = (r_wr == TQ_AW'(TQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == TQ_AW'(TQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push_valid && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push_valid && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_valid) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

endmodule

// File: rtl/core/utfve_back.sv
// Back end: expands queued tokens into output bytes through a registered output stage.
// Depends on utfve_pkg and utfve_out_if.
module utfve_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  utfve_pkg::t_tok  i_head_tok,
    output logic             o_pop,
    utfve_out_if.source      o_out
);
    import utfve_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    logic [2:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       load;
    logic       last_byte;
    logic [2:0] nib_k;
    logic [3:0] nib;
    logic [7:0] hex_ch;
    logic [7:0] cur_byte;

    assign load      = i_head_valid && (!r_out_valid || o_out.ready);
    assign last_byte = ({1'b0, r_idx} == (i_head_tok.total - 4'd1));
    assign nib_k     = i_head_tok.ndig + 3'd1 - r_idx;
    assign nib       = i_head_tok.data[{nib_k, 2'b00} +: 4];
    assign hex_ch    = (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});

    always_comb begin
        if (!i_head_tok.esc) begin
            cur_byte = i_head_tok.data[{r_idx[1:0], 3'b000} +: 8];
        end else if (r_idx == 3'd0) begin
            cur_byte = CH_BSLASH;
        end else if (r_idx == 3'd1) begin
            cur_byte = i_head_tok.is_u ? CH_LOW_U : CH_LOW_X;
        end else begin
            cur_byte = hex_ch;
        end
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = last_byte ? 3'd0 : r_idx + 3'd1;
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_pop = load && last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_last <= i_head_tok.last && last_byte;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_validate_and_escape: directed and random text bytes,
// each checked byte for byte against an in-bench escaping predictor.
// Depends on the two channel interfaces and the top module.
module tb;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          MAX_RUN        = 16;
    localparam logic [7:0]  CH_BSLASH      = 8'h5C;
    localparam logic [7:0]  CH_X           = 8'h78;
    localparam logic [7:0]  CH_U           = 8'h75;
    localparam logic [7:0]  CH_ZERO        = 8'h30;
    localparam logic [7:0]  CH_LOWER_A     = 8'h61;

    typedef enum int {SEQ_OK, SEQ_WAIT, SEQ_BAD} t_seq_state;
    typedef enum int {
        BRK_TRUNC, BRK_BAD_CONT, BRK_LONE_LEAD, BRK_OVERLONG, BRK_SURROGATE, BRK_TOO_HIGH
    } t_brk_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_esc_byte;

    logic        clk;
    logic        rst_n;
    utfve_in_if  in_ch ();
    utfve_out_if out_ch ();

    t_esc_byte   escaped_q[$];
    t_esc_byte   head;
    logic [7:0]  run_bytes[$];
    logic [7:0]  held [3];
    int          held_cnt     = 0;
    int          err_count    = 0;
    int unsigned sent_bytes   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned rdy_hold     = 0;
    bit          src_idle_en  = 1'b0;
    bit          sink_idle_en = 1'b0;

    utf8_validate_and_escape u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return CH_ZERO + d;
        return CH_LOWER_A + (d - 4'd10);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] seq);
        if (cp < 21'h80) begin
            seq = {24'h0, cp[7:0]};
            return 1;
        end
        if (cp < 21'h800) begin
            seq = {16'h0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            seq = {8'h0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
            return 3;
        end
        seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic logic [20:0] rand_cp();
        int unsigned roll;
        logic [20:0] cp;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            cp = 21'($urandom_range('h20, 'h7E));
        end else if (roll < 42) begin
            cp = ($urandom_range(0, 32) == 32) ? 21'h7F : 21'($urandom_range(0, 'h1F));
        end else if (roll < 57) begin
            cp = 21'($urandom_range('h80, 'h7FF));
        end else if (roll < 72) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
        end else if (roll < 84) begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
        end else begin
            // Hidden code points and their immediate neighbors.
            case ($urandom_range(0, 5))
                0: begin
                    case ($urandom_range(0, 15))
                        0:  cp = 21'hAD;
                        1:  cp = 21'h34F;
                        2:  cp = 21'h61C;
                        3:  cp = 21'h115F;
                        4:  cp = 21'h1160;
                        5:  cp = 21'h17B4;
                        6:  cp = 21'h17B5;
                        7:  cp = 21'h180E;
                        8:  cp = 21'h3164;
                        9:  cp = 21'hFEFF;
                        10: cp = 21'hFFA0;
                        11: cp = 21'h80;
                        12: cp = 21'h9F;
                        13: cp = 21'hA0;
                        14: cp = 21'hAC;
                        default: cp = 21'hAE;
                    endcase
                end
                1: cp = 21'h200A + 21'($urandom_range(0, 6));
                2: cp = 21'h2027 + 21'($urandom_range(0, 8));
                3: cp = 21'h205F + 21'($urandom_range(0, 17));
                4: cp = $urandom_range(0, 1) ? 21'hFDFF + 21'($urandom_range(0, 17))
                                             : 21'hFFEF + 21'($urandom_range(0, 13));
                default: cp = 21'hDFFFF + 21'($urandom_range(0, 'h1001));
            endcase
        end
        return cp;
    endfunction

    task automatic push_x(input logic [7:0] v);
        run_bytes.push_back(CH_BSLASH);
        run_bytes.push_back(CH_X);
        run_bytes.push_back(hex_char(v[7:4]));
        run_bytes.push_back(hex_char(v[3:0]));
    endtask

    // Resolves the held bytes plus the new one and queues the escaped bytes they give.
    task automatic escape_predict(input logic [7:0] b, input logic eot);
        logic [7:0] seq [4];
        logic [7:0] lead;
        logic [20:0] acc;
        logic [23:0] v;
        t_seq_state state;
        t_esc_byte item;
        int n, pos, len, i, d, digits;
        bit stop;
        run_bytes.delete();
        for (i = 0; i < held_cnt; i++) seq[i] = held[i];
        seq[held_cnt] = b;
        n = held_cnt + 1;
        pos = 0;
        stop = 1'b0;
        while (pos < n && !stop) begin
            lead = seq[pos];
            state = SEQ_OK;
            acc = '0;
            len = 1;
            if (lead < 8'h80) begin
                acc = {13'h0, lead};
            end else begin
                if (lead >= 8'hC2 && lead <= 8'hDF) begin
                    len = 2;
                    acc = {16'h0, lead[4:0]};
                end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
                    len = 3;
                    acc = {17'h0, lead[3:0]};
                end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
                    len = 4;
                    acc = {18'h0, lead[2:0]};
                end else begin
                    state = SEQ_BAD;
                end
                for (i = 1; i < len; i++) begin
                    if (state == SEQ_OK) begin
                        if (pos + i >= n) state = eot ? SEQ_BAD : SEQ_WAIT;
                        else if (seq[pos + i][7:6] != 2'b10) state = SEQ_BAD;
                        else acc = {acc[14:0], seq[pos + i][5:0]};
                    end
                end
                if (state == SEQ_OK && ((len == 3 && acc < 21'h800) ||
                        (len == 4 && acc < 21'h10000) || acc > 21'h10FFFF ||
                        (acc >= 21'hD800 && acc <= 21'hDFFF)))
                    state = SEQ_BAD;
            end
            case (state)
                SEQ_WAIT: stop = 1'b1;
                SEQ_BAD: begin
                    push_x(lead);
                    pos++;
                end
                default: begin
                    if (acc < 21'h20 || acc == 21'h7F) begin
                        push_x(acc[7:0]);
                    end else if ((acc >= 21'h80 && acc <= 21'h9F) || acc == 21'hAD ||
                            acc == 21'h34F || acc == 21'h61C || acc == 21'h115F ||
                            acc == 21'h1160 || acc == 21'h17B4 || acc == 21'h17B5 ||
                            acc == 21'h180E || (acc >= 21'h200B && acc <= 21'h200F) ||
                            (acc >= 21'h2028 && acc <= 21'h202E) ||
                            (acc >= 21'h2060 && acc <= 21'h206F) || acc == 21'h3164 ||
                            (acc >= 21'hFE00 && acc <= 21'hFE0F) || acc == 21'hFEFF ||
                            acc == 21'hFFA0 || (acc >= 21'hFFF0 && acc <= 21'hFFFB) ||
                            (acc >= 21'hE0000 && acc <= 21'hE0FFF)) begin
                        v = {3'b000, acc};
                        digits = (acc > 21'hFFFFF) ? 6 : (acc > 21'hFFFF) ? 5 : 4;
                        run_bytes.push_back(CH_BSLASH);
                        run_bytes.push_back(CH_U);
                        for (d = digits - 1; d >= 0; d--)
                            run_bytes.push_back(hex_char(v[4*d +: 4]));
                    end else begin
                        for (i = 0; i < len; i++) run_bytes.push_back(seq[pos + i]);
                    end
                    pos += len;
                end
            endcase
        end
        held_cnt = n - pos;
        for (i = 0; i < held_cnt; i++) held[i] = seq[pos + i];
        n = (run_bytes.size() > MAX_RUN) ? MAX_RUN : run_bytes.size();
        for (i = 0; i < n; i++) begin
            item.ch = run_bytes[i];
            item.last = (i == n - 1);
            escaped_q.push_back(item);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap != 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            in_ch.in_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (!in_ch.ready);
        sent_bytes++;
        escape_predict(b, eot);
    endtask

    task automatic send_run(input logic [31:0] seq, input int len, input logic eot);
        int i;
        for (i = 0; i < len; i++) send_byte(seq[8*(len - 1 - i) +: 8], eot && (i == len - 1));
    endtask

    task automatic send_broken(input logic eot);
        logic [31:0] seq;
        logic [20:0] cp;
        logic [7:0] bad;
        t_brk_kind kind;
        int len, j;
        kind = t_brk_kind'($urandom_range(0, 5));
        case (kind)
            BRK_TRUNC, BRK_BAD_CONT: begin
                do cp = rand_cp(); while (cp < 21'h80);
                len = utf8_encode(cp, seq);
                if (kind == BRK_TRUNC) begin
                    seq = seq >> 8;
                    len--;
                end else begin
                    j = $urandom_range(1, len - 1);
                    bad = 8'($urandom);
                    if (bad[7:6] == 2'b10) bad[6] = 1'b1;
                    seq[8*(len - 1 - j) +: 8] = bad;
                end
            end
            BRK_LONE_LEAD: begin
                len = 1;
                case ($urandom_range(0, 2))
                    0: seq = $urandom_range('h80, 'hBF);
                    1: seq = $urandom_range('hC0, 'hC1);
                    default: seq = $urandom_range('hF5, 'hFF);
                endcase
            end
            BRK_OVERLONG: begin
                case ($urandom_range(0, 2))
                    0: begin
                        len = 2;
                        seq = {16'h0, 8'($urandom_range('hC0, 'hC1)), cont_byte()};
                    end
                    1: begin
                        len = 3;
                        seq = {8'h0, 8'hE0, 8'($urandom_range('h80, 'h9F)), cont_byte()};
                    end
                    default: begin
                        len = 4;
                        seq = {8'hF0, 8'($urandom_range('h80, 'h8F)), cont_byte(), cont_byte()};
                    end
                endcase
            end
            BRK_SURROGATE: begin
                len = 3;
                seq = {8'h0, 8'hED, 8'($urandom_range('hA0, 'hBF)), cont_byte()};
            end
            default: begin
                len = 4;
                if ($urandom_range(0, 1))
                    seq = {8'hF4, 8'($urandom_range('h90, 'hBF)), cont_byte(), cont_byte()};
                else
                    seq = {8'($urandom_range('hF5, 'hF7)), cont_byte(), cont_byte(), cont_byte()};
            end
        endcase
        send_run(seq, len, eot);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (escaped_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("%0t: %s mismatch, got %02h, expected %02h", $time, what, got, want);
    endtask

    task automatic test_ascii_edges();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        send_run(32'h00, 1, 1'b0);
        send_run(32'h7F, 1, 1'b0);
        send_run(32'h7E, 1, 1'b0);
        send_run(32'h20, 1, 1'b1);
    endtask

    task automatic test_valid_sequences();
        send_run(32'hC280, 2, 1'b0);
        send_run(32'hE2808B, 3, 1'b0);
        send_run(32'hF48FBFBF, 4, 1'b0);
        send_run(32'hF3A08080, 4, 1'b1);
    endtask

    task automatic test_broken_sequences();
        send_run(32'hFF, 1, 1'b0);
        send_run(32'hE241, 2, 1'b0);
        send_run(32'hEDA080, 3, 1'b0);
        send_run(32'hF0808080, 4, 1'b0);
        send_run(32'hE282, 2, 1'b1);
    endtask

    task automatic test_mixed_text(input int unsigned n_bytes, input bit idle_en);
        logic [31:0] seq;
        int unsigned start;
        int len;
        src_idle_en = idle_en;
        sink_idle_en = idle_en;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes) begin
            if ($urandom_range(0, 99) < 85) begin
                len = utf8_encode(rand_cp(), seq);
                send_run(seq, len, $urandom_range(0, 15) == 0);
            end else begin
                send_broken($urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_byte_noise(input int unsigned n_bytes);
        int unsigned i;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        for (i = 0; i < n_bytes; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    always @(negedge clk) begin
        if (sink_idle_en && rdy_hold != 0) begin
            out_ch.ready <= 1'b0;
            rdy_hold--;
        end else begin
            out_ch.ready <= 1'b1;
            rdy_hold = sink_idle_en ? pick_gap() : 0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (escaped_q.size() == 0) begin
                report_mismatch("unexpected byte", out_ch.out_byte, 8'h00);
            end else begin
                head = escaped_q.pop_front();
                if (out_ch.out_byte !== head.ch)
                    report_mismatch("out_byte", out_ch.out_byte, head.ch);
                if (out_ch.last_of_run !== head.last)
                    report_mismatch("last_of_run", {7'h0, out_ch.last_of_run},
                                    {7'h0, head.last});
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_ascii_edges();
        test_valid_sequences();
        test_broken_sequences();
        wait_drained();
        test_mixed_text(250, 1'b1);
        wait_drained();
        test_mixed_text(110, 1'b0);
        wait_drained();
        test_byte_noise(80);
        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
